// File: hdl/isort_pkg.sv
package isort_pkg;

   localparam int VALUE_W     = 32;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 1;

   typedef struct packed {
      logic insert;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic last_one;
   } status_type;

endpackage

// File: hdl/isort_ctrl.sv
module isort_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output isort_pkg::cmd_type    cmd,
   input  isort_pkg::status_type status
);
   import isort_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid && req_tlast) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready && status.last_one) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign cmd.insert = req_tvalid && req_tready;
   assign cmd.pop    = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/isort_datapath.sv
module isort_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [isort_pkg::VALUE_W-1:0]  value,
   input  isort_pkg::cmd_type                    cmd,
   output isort_pkg::status_type                 status,
   output logic signed [isort_pkg::VALUE_W-1:0]  sorted_value,
   output logic                                  last_out,
   output logic                                  overflow
);
   import isort_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic signed [VALUE_W-1:0] data_ff [CAPACITY];
   logic signed [VALUE_W-1:0] data_in [CAPACITY];
   logic signed [VALUE_W-1:0] placed  [CAPACITY];
   logic [CAPACITY-1:0]       keep;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      dropped_ff, dropped_in;
   logic                      full;

   assign full = (count_ff == CNT_W'(CAPACITY));

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         assign keep[g] = (CNT_W'(g) < count_ff) && !(data_ff[g] > value);
         if (g == 0) begin : g_head
            assign placed[g] = keep[g] ? data_ff[g] : value;
         end else begin : g_body
            assign placed[g] = keep[g]     ? data_ff[g]   :
                               keep[g-1]   ? value        : data_ff[g-1];
         end
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         data_in[i] = data_ff[i];
         if (cmd.insert && !full) begin
            data_in[i] = placed[i];
         end else if (cmd.pop && (i < CAPACITY - 1)) begin
            data_in[i] = data_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.insert) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
         if (status.last_one) begin
            dropped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         data_ff[i] <= data_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign status.last_one = (count_ff == CNT_W'(1));
   assign sorted_value    = data_ff[0];
   assign last_out        = status.last_one;
   assign overflow        = dropped_ff;

endmodule

// File: hdl/insertion_sorter.sv
// Sorts one run of signed 32-bit values, ascending, equal values in arrival order. A run
// is streamed in at one value per cycle, its final value marked by req_tlast; each value
// is placed into a row of CAPACITY registers by a parallel compare against every held
// entry. After the marked value the block stops accepting and emits the held list
// smallest first, one transaction per cycle while rsp_tready is high, from the head
// of the row, rsp_tlast on the final one, then takes the next run. Values beyond
// CAPACITY are dropped and every result of that run carries rsp_tuser (overflow) high.
module insertion_sorter #(
   parameter int CAPACITY = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [isort_pkg::REQ_TDATA_W-1:0]    req_tdata,  // value
   input  logic                                 req_tlast,  // last_item
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [isort_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // sorted_value
   output logic                                 rsp_tlast,  // last_out
   output logic [isort_pkg::RSP_TUSER_W-1:0]    rsp_tuser   // overflow
);
   import isort_pkg::*;

   cmd_type                   cmd;
   status_type                status;
   logic signed [VALUE_W-1:0] sorted_value;
   logic                      overflow;

   isort_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   isort_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .value        (signed'(req_tdata[VALUE_W-1:0])),
      .cmd          (cmd),
      .status       (status),
      .sorted_value (sorted_value),
      .last_out     (rsp_tlast),
      .overflow     (overflow)
   );

   assign rsp_tdata = RSP_TDATA_W'(unsigned'(sorted_value));
   assign rsp_tuser = RSP_TUSER_W'(overflow);

endmodule

// File: hdl/isort_checker.sv
module isort_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [isort_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [isort_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                              rsp_tlast,
   input logic [isort_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import isort_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while draining");

   a_drain_start: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid && !req_tready)
      else $error("drain did not follow last input transaction");

   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("block did not return to load after final result");

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);
